@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk_i, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion that stays active during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/hpc_pkg.sv @@
// -----------------------------------------------------------------------------
// hpc_pkg
// Shared types and constants for the half precision converter.
// -----------------------------------------------------------------------------
package hpc_pkg;

  typedef enum logic [1:0] {
    OP_F32_TO_F16 = 2'd0,
    OP_I32_TO_F16 = 2'd1,
    OP_F16_TO_F32 = 2'd2,
    OP_F16_TO_I32 = 2'd3
  } hpc_op_e;

  localparam logic [15:0] HalfMaxMag = 16'h7BFF;

  // Stage 1 -> stage 2 payload: source decoded into sign, exponent, a 32-bit
  // significand window and a right shift that brings it to the result grid.
  typedef struct packed {
    hpc_op_e     op;
    logic        sign;
    logic        sat;      // force largest finite half or saturated int
    logic        zero;     // force (signed) zero
    logic [8:0]  exp;      // target biased exponent before rounding
    logic [31:0] sig;      // significand, msb aligned per op
    logic [5:0]  shamt;    // right shift before rounding
  } dec_t;

  // Stage 2 -> stage 3 payload: shifted value and rounding bits.
  typedef struct packed {
    hpc_op_e     op;
    logic        sign;
    logic        sat;
    logic        zero;
    logic [8:0]  exp;
    logic [31:0] kept;
    logic        rbit;
    logic        sticky;
  } shf_t;

  // Count leading zeros of a 32-bit value, 32 for zero.
  function automatic logic [5:0] clz32(input logic [31:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/hpc_if.sv @@
// -----------------------------------------------------------------------------
// hpc_in_if / hpc_out_if
// Valid/ready channels carrying converter operands and results.
// -----------------------------------------------------------------------------
interface hpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] operand;
  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface hpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

@@ hw/rtl/hpc_decode.sv @@
// -----------------------------------------------------------------------------
// hpc_decode
// Stage 1 logic: unpacks the operand and works out exponent and shift.
// -----------------------------------------------------------------------------
module hpc_decode (
  input  logic [1:0]   opcode_i,
  input  logic [31:0]  operand_i,
  output hpc_pkg::dec_t dec_o
);
  import hpc_pkg::*;

  logic [7:0]  fe;
  logic [22:0] fm;
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [31:0] mag;
  logic [5:0]  lz;
  logic [10:0] hsig;
  logic [5:0]  hlz;
  logic [5:0]  len;

  assign fe   = operand_i[30:23];
  assign fm   = operand_i[22:0];
  assign he   = operand_i[14:10];
  assign hm   = operand_i[9:0];
  assign mag  = operand_i[31] ? (~operand_i + 32'd1) : operand_i;
  assign lz   = clz32(mag);
  assign len  = 6'd32 - lz;
  assign hsig = {(he != 5'd0), hm};
  assign hlz  = clz32({21'd0, hsig});

  always_comb begin
    dec_o = '0;
    dec_o.op = hpc_op_e'(opcode_i);
    unique case (hpc_op_e'(opcode_i))
      OP_F32_TO_F16: begin
        // sig holds 1.m at bits 31..8; result mantissa lands in bits 10..0
        dec_o.sign = operand_i[31];
        dec_o.sig  = {1'b1, fm, 8'd0};
        if (fe > 8'h8F) begin
          dec_o.sat = 1'b1;
        end else if (fe > 8'h70) begin
          dec_o.exp   = {1'b0, fe} - 9'h70;
          dec_o.shamt = 6'd21;
        end else if (fe >= 8'h66) begin
          // subnormal: shift right 21 + (0x71 - e); at 0x66 all bits fall into round/sticky
          dec_o.exp   = 9'd0;
          dec_o.shamt = 6'd21 + 6'(8'h71 - fe);
        end else begin
          dec_o.zero = 1'b1;
        end
      end
      OP_I32_TO_F16: begin
        dec_o.sign = operand_i[31];
        dec_o.sig  = mag << lz;
        dec_o.exp  = 9'(len) + 9'd14;
        dec_o.shamt = 6'd21;
        if (operand_i == 32'd0) begin
          dec_o.zero = 1'b1;
          dec_o.sign = 1'b0;
        end
      end
      OP_F16_TO_F32: begin
        dec_o.sign = operand_i[15];
        dec_o.sig  = {21'd0, hsig} << hlz;
        dec_o.exp  = 9'd112 + {4'd0, he} + {8'd0, he == 5'd0} - 9'(hlz - 6'd21);
        dec_o.zero = (hsig == 11'd0);
      end
      OP_F16_TO_I32: begin
        dec_o.sign = operand_i[15];
        dec_o.sat  = (he == 5'd31);
        dec_o.sig  = {hsig, 21'd0};
        // integer value = sig >> (31 - (e - 15)); e==0 acts like e==1
        if (he == 5'd0) dec_o.shamt = 6'd45;
        else if (he >= 5'd15) dec_o.shamt = 6'(6'd46 - {1'b0, he});
        else dec_o.shamt = 6'(6'd46 - {1'b0, he});
      end
      default: ;
    endcase
  end
endmodule

@@ hw/rtl/hpc_shift.sv @@
// -----------------------------------------------------------------------------
// hpc_shift
// Stage 2 logic: right shift with round and sticky bit extraction.
// -----------------------------------------------------------------------------
module hpc_shift (
  input  hpc_pkg::dec_t dec_i,
  output hpc_pkg::shf_t shf_o
);
  import hpc_pkg::*;

  logic [63:0] ext;
  logic [63:0] sh;

  assign ext = {dec_i.sig, 32'd0};
  assign sh  = (dec_i.shamt > 6'd32) ? (ext >> 32) >> (dec_i.shamt - 6'd32)
                                     : ext >> dec_i.shamt;

  always_comb begin
    shf_o.op     = dec_i.op;
    shf_o.sign   = dec_i.sign;
    shf_o.sat    = dec_i.sat;
    shf_o.zero   = dec_i.zero;
    shf_o.exp    = dec_i.exp;
    shf_o.kept   = sh[63:32];
    shf_o.rbit   = sh[31];
    shf_o.sticky = (sh[30:0] != 31'd0) || (dec_i.shamt > 6'd32 &&
                   (({32'd0, ext[63:32]} & ((64'd1 << (dec_i.shamt - 6'd32)) - 64'd1)
                     ) != 64'd0));
  end
endmodule

@@ hw/rtl/hpc_pack.sv @@
// -----------------------------------------------------------------------------
// hpc_pack
// Stage 3 logic: rounds to nearest even and packs the result word.
// -----------------------------------------------------------------------------
module hpc_pack (
  input  hpc_pkg::shf_t shf_i,
  output logic [31:0]   result_o
);
  import hpc_pkg::*;

  logic        rup;
  logic [32:0] rnd;
  logic [8:0]  e2;
  logic [9:0]  hmf;
  logic [31:0] ival;
  logic [15:0] half;

  assign rup = shf_i.rbit && (shf_i.sticky || shf_i.kept[0]);
  assign rnd = {1'b0, shf_i.kept} + {32'd0, rup};

  always_comb begin
    e2   = shf_i.exp;
    hmf  = rnd[9:0];
    half = '0;
    ival = '0;
    result_o = '0;
    unique case (shf_i.op)
      OP_F32_TO_F16, OP_I32_TO_F16: begin
        if (rnd[11]) begin
          e2  = shf_i.exp + 9'd1;
          hmf = rnd[10:1];
        end else if (shf_i.exp == 9'd0 && rnd[10]) begin
          e2 = 9'd1;  // subnormal rounded up to smallest normal
        end
        if (shf_i.sat || e2 >= 9'd31) half = {shf_i.sign, HalfMaxMag[14:0]};
        else if (shf_i.zero) half = {shf_i.sign, 15'd0};
        else half = {shf_i.sign, e2[4:0], hmf};
        result_o = {16'd0, half};
      end
      OP_F16_TO_F32: begin
        if (shf_i.zero) result_o = {shf_i.sign, 31'd0};
        else result_o = {shf_i.sign, shf_i.exp[7:0], shf_i.kept[30:8]};
      end
      OP_F16_TO_I32: begin
        ival = (rup && shf_i.kept != 32'h7FFF_FFFF) ? rnd[31:0] : shf_i.kept;
        if (shf_i.sat) result_o = shf_i.sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else result_o = shf_i.sign ? (~ival + 32'd1) : ival;
      end
      default: ;
    endcase
  end
endmodule

@@ hw/rtl/half_precision_converter.sv @@
// Three register stages (s1_q, s2_q, r3_q) lie between input beat and result beat.
// Throughput: one beat per cycle; the pipeline advances whenever the last
// stage is empty or its result is taken, so ready tracks only that.
// Reset: rst_ni clears all stage valid bits; payload registers are not reset.
// -----------------------------------------------------------------------------
// half_precision_converter
// Pipelined fp16 <-> fp32 / int32 conversion with round to nearest even.
// -----------------------------------------------------------------------------
module half_precision_converter (
  input  logic  clk_i,
  input  logic  rst_ni,
  hpc_in_if.sink    in_i,
  hpc_out_if.source out_o
);
  import hpc_pkg::*;
  `include "assert_macros.svh"

  logic          v1_q, v2_q, v3_q;
  dec_t          s1_q, dec_d;
  shf_t          s2_q, shf_d;
  logic [31:0]   r3_q, res_d;
  logic          adv;

  assign adv       = !v3_q || out_o.ready;
  assign in_i.ready = adv;
  assign out_o.valid  = v3_q;
  assign out_o.result = r3_q;

  hpc_decode u_dec (.opcode_i(in_i.opcode), .operand_i(in_i.operand), .dec_o(dec_d));
  hpc_shift  u_shf (.dec_i(s1_q), .shf_o(shf_d));
  hpc_pack   u_pck (.shf_i(s2_q), .result_o(res_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= dec_d;
      s2_q <= shf_d;
      r3_q <= res_d;
    end
  end

  `ASSERT_CLK(a_stall_hold, (v3_q && !out_o.ready) |=> (v3_q && $stable(r3_q)), "result lost on stall")
  `ASSERT_CLK(a_ready_free, !v3_q |-> in_i.ready, "ready low with empty output")
  `ASSERT_CLK(a_flow, (adv && v2_q) |=> v3_q, "beat dropped between stages")
endmodule
